### sv/tpsg_pkg.sv
package tpsg_pkg;

    localparam int MOTOR_COUNT      = 2;
    localparam int DUTY_BITS        = 10;
    localparam int PHASE_BITS       = 16;
    localparam int SINE_TABLE_DEPTH = 1024;

    localparam int MOTOR_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int ROM_W   = $clog2(SINE_TABLE_DEPTH);
    localparam int QTR_W   = ROM_W - 2;
    localparam int QTR_DEPTH = SINE_TABLE_DEPTH / 4;

    // Q1.14 speed and sine, products in Q2.28
    localparam int SPEED_W    = 16;
    localparam int AMP_W      = 15;
    localparam int SIN_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int DB_W       = 15;
    localparam int DIR_W      = 2;
    localparam int SPEED_ONE  = 16384;
    localparam int STEP_SHIFT = 14;
    localparam int MUL_W      = 17;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int BIAS_W     = 30;
    localparam int DUTY_SHIFT = 29;
    localparam int SCALED_W   = BIAS_W + DUTY_BITS;
    localparam logic [BIAS_W-1:0] PROD_BIAS = BIAS_W'(1 << 28);

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = SPEED_W'(SPEED_ONE);
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = SPEED_W'(-SPEED_ONE);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

    localparam logic [PHASE_BITS-1:0] PHASE_THIRD =
        PHASE_BITS'(((64'd1 << PHASE_BITS) + 64'd1) / 64'd3);
    localparam logic [PHASE_BITS-1:0] PHASE_TWO_THIRDS =
        PHASE_BITS'(((64'd1 << (PHASE_BITS + 1)) + 64'd1) / 64'd3);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [PHASE_BITS-1:0]   t_phase;
    typedef logic [DUTY_BITS-1:0]    t_duty;
    typedef logic signed [SIN_W-1:0] t_sine;
    typedef logic [AMP_W-1:0]        t_qval;
    typedef t_qval                   t_qsine_rom [QTR_DEPTH];

    typedef enum logic [DIR_W-1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        PH_U = 2'd0,
        PH_V = 2'd1,
        PH_W = 2'd2
    } t_phase_sel;

    typedef enum logic {
        MUL_SINE = 1'b0,
        MUL_STEP = 1'b1
    } t_mul_sel;

    typedef enum logic {
        CFG_GAIN     = 1'b0,
        CFG_DEADBAND = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_LOOK  = 3'd1,
        ST_MUL_U = 3'd2,
        ST_MUL_V = 3'd3,
        ST_MUL_W = 3'd4,
        ST_STEP  = 3'd5,
        ST_DONE  = 3'd6
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       sin_en;
        t_phase_sel sin_sel;
        logic       mul_en;
        t_mul_sel   mul_sel;
        logic [2:0] duty_en;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic out_stall;
    } t_stat;

    // Quarter-wave sine, odd Taylor series to x^9 in unsigned Q2.30
    function automatic t_qval qsine_calc(input int unsigned rr);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = (64'(rr) * 64'd4 * HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2))
             / 64'(SINE_TABLE_DEPTH);
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        s  = (s + (64'd1 << 15)) >> 16;
        if (s > 64'(SPEED_ONE)) begin
            s = 64'(SPEED_ONE);
        end
        return AMP_W'(s);
    endfunction

    function automatic t_qsine_rom build_qsine();
        t_qsine_rom rom;
        for (int i = 0; i < QTR_DEPTH; i++) begin
            rom[i] = qsine_calc(i);
        end
        return rom;
    endfunction

    localparam t_qsine_rom QSINE      = build_qsine();
    localparam t_qval      QSINE_PEAK = qsine_calc(QTR_DEPTH);

    // Full-wave sine from quarter-wave table by mirror and sign
    function automatic t_sine sine_lookup(input logic [ROM_W-1:0] idx);
        logic [1:0]       quad;
        logic [QTR_W-1:0] r;
        logic [QTR_W-1:0] r_mirror;
        t_qval            v;
        quad     = idx[ROM_W-1 -: 2];
        r        = idx[QTR_W-1:0];
        r_mirror = QTR_W'(0) - r;
        if (quad[0]) begin
            v = (r == '0) ? QSINE_PEAK : QSINE[r_mirror];
        end else begin
            v = QSINE[r];
        end
        return quad[1] ? -t_sine'({1'b0, v}) : t_sine'({1'b0, v});
    endfunction

endpackage

### sv/tpsg_if.sv
interface tpsg_in_if;
    import tpsg_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      motor_select;
    logic signed [SPEED_W-1:0] speed_command;

    modport source (output valid, output motor_select, output speed_command, input ready);
    modport sink   (input valid, input motor_select, input speed_command, output ready);
endinterface

interface tpsg_out_if;
    import tpsg_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 motor_echo;
    logic [DUTY_BITS-1:0] duty_u;
    logic [DUTY_BITS-1:0] duty_v;
    logic [DUTY_BITS-1:0] duty_w;
    logic [DIR_W-1:0]     direction;

    modport source (output valid, output motor_echo, output duty_u, output duty_v,
                    output duty_w, output direction, input ready);
    modport sink   (input valid, input motor_echo, input duty_u, input duty_v,
                    input duty_w, input direction, output ready);
endinterface

### sv/tpsg_cfg.sv
module tpsg_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tpsg_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [tpsg_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [tpsg_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic [tpsg_pkg::GAIN_W-1:0]       o_gain,
    output logic [tpsg_pkg::DB_W-1:0]         o_deadband
);
    import tpsg_pkg::*;

    logic [GAIN_W-1:0] r_gain;
    logic [DB_W-1:0]   r_deadband;
    logic              wr_en;
    t_cfg_idx          idx;

    assign idx    = t_cfg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= GAIN_W'(1043);
            r_deadband <= DB_W'(819);
        end else if (wr_en) begin
            case (idx)
                CFG_GAIN:     r_gain     <= pwdata[GAIN_W-1:0];
                CFG_DEADBAND: r_deadband <= pwdata[DB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            CFG_GAIN:     prdata = CFG_DATA_W'(r_gain);
            CFG_DEADBAND: prdata = CFG_DATA_W'(r_deadband);
            default:      prdata = '0;
        endcase
    end

    assign o_gain     = r_gain;
    assign o_deadband = r_deadband;
endmodule

### sv/tpsg_ctrl.sv
module tpsg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  tpsg_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output tpsg_pkg::t_cmd  o_cmd
);
    import tpsg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_LOOK;
            ST_LOOK:  n_state = ST_MUL_U;
            ST_MUL_U: n_state = ST_MUL_V;
            ST_MUL_V: n_state = ST_MUL_W;
            ST_MUL_W: n_state = ST_STEP;
            ST_STEP:  n_state = ST_DONE;
            ST_DONE:  if (!i_stat.out_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        o_cmd.sin_sel   = PH_U;
        o_cmd.mul_sel   = MUL_SINE;
        case (r_state)
            ST_IDLE: begin
                // hold off the input while reset is applied
                o_in_ready   = i_rst_n;
                o_cmd.accept = i_in_valid && i_rst_n;
            end
            ST_LOOK: begin
                o_cmd.sin_en  = 1'b1;
                o_cmd.sin_sel = PH_U;
            end
            ST_MUL_U: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.sin_en  = 1'b1;
                o_cmd.sin_sel = PH_V;
            end
            ST_MUL_V: begin
                o_cmd.duty_en = 3'b001;
                o_cmd.mul_en  = 1'b1;
                o_cmd.sin_en  = 1'b1;
                o_cmd.sin_sel = PH_W;
            end
            ST_MUL_W: begin
                o_cmd.duty_en = 3'b010;
                o_cmd.mul_en  = 1'b1;
            end
            ST_STEP: begin
                o_cmd.duty_en = 3'b100;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_STEP;
            end
            ST_DONE: begin
                o_cmd.finish = !i_stat.out_stall;
            end
            default: ;
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == ST_LOOK)
        else $error("accepted beat did not start the sequence");

    a_done_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_stat.out_stall) |=> r_state == ST_IDLE)
        else $error("finished item did not return to idle");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == ST_IDLE)
        else $error("input ready outside idle");
endmodule

### sv/tpsg_dp.sv
module tpsg_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tpsg_pkg::t_cmd                    i_cmd,
    output tpsg_pkg::t_stat                   o_stat,
    input  logic                              i_motor_select,
    input  logic signed [tpsg_pkg::SPEED_W-1:0] i_speed_command,
    input  logic [tpsg_pkg::GAIN_W-1:0]       i_gain,
    input  logic [tpsg_pkg::DB_W-1:0]         i_deadband,
    tpsg_out_if.source                        o_out
);
    import tpsg_pkg::*;

    // per-motor phase accumulators
    logic [MOTOR_COUNT-1:0][PHASE_BITS-1:0] r_phase_mem;

    logic                      r_sel;
    logic [MOTOR_W-1:0]        r_motor;
    logic signed [SPEED_W-1:0] r_speed;
    t_qval                     r_amp;
    t_dir                      r_dir;
    t_phase                    r_phase;
    t_sine                     r_sin;
    logic signed [PROD_W-1:0]  r_prod;
    t_duty                     r_duty_u;
    t_duty                     r_duty_v;
    t_duty                     r_duty_w;

    logic  r_out_valid;
    logic  r_out_sel;
    t_duty r_out_u;
    t_duty r_out_v;
    t_duty r_out_w;
    t_dir  r_out_dir;

    logic signed [SPEED_W-1:0] speed_c;
    logic signed [SPEED_W:0]   speed_x;
    logic signed [SPEED_W:0]   db_x;
    t_dir                      dir_c;
    t_qval                     amp_c;
    logic [MOTOR_W-1:0]        motor_c;
    t_phase                    ph_sel;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic [BIAS_W-1:0]         biased;
    logic [SCALED_W-1:0]       scaled;
    t_duty                     duty_c;
    t_phase                    delta;

    // saturate speed, classify direction, take the amplitude and clamp the motor index
    always_comb begin
        if (i_speed_command > SPEED_MAX) begin
            speed_c = SPEED_MAX;
        end else if (i_speed_command < SPEED_MIN) begin
            speed_c = SPEED_MIN;
        end else begin
            speed_c = i_speed_command;
        end
        speed_x = (SPEED_W + 1)'(speed_c);
        db_x    = signed'({2'b00, i_deadband});
        if (speed_x > db_x) begin
            dir_c = DIR_FWD;
        end else if (speed_x < -db_x) begin
            dir_c = DIR_BACK;
        end else begin
            dir_c = DIR_STOP;
        end
        amp_c = (speed_c < 0) ? AMP_W'(-speed_c) : AMP_W'(speed_c);
        if (32'(i_motor_select) >= MOTOR_COUNT) begin
            motor_c = MOTOR_W'(MOTOR_COUNT - 1);
        end else begin
            motor_c = MOTOR_W'(i_motor_select);
        end
    end

    always_comb begin
        case (i_cmd.sin_sel)
            PH_U:    ph_sel = r_phase;
            PH_V:    ph_sel = r_phase - PHASE_THIRD;
            PH_W:    ph_sel = r_phase - PHASE_TWO_THIRDS;
            default: ph_sel = r_phase;
        endcase
    end

    // one shared multiplier: amp * sine, then speed * gain
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SINE: begin
                mul_a = signed'({2'b00, r_amp});
                mul_b = MUL_W'(r_sin);
            end
            MUL_STEP: begin
                mul_a = MUL_W'(r_speed);
                mul_b = signed'({1'b0, i_gain});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // duty = floor((prod + 2^28) * (2^DUTY_BITS - 1) / 2^29)
    assign biased = BIAS_W'(r_prod) + PROD_BIAS;
    assign scaled = {biased, DUTY_BITS'(0)} - SCALED_W'(biased);
    assign duty_c = scaled[DUTY_SHIFT +: DUTY_BITS];
    assign delta  = t_phase'(r_prod >>> STEP_SHIFT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sel   <= i_motor_select;
            r_motor <= motor_c;
            r_speed <= speed_c;
            r_amp   <= amp_c;
            r_dir   <= dir_c;
            r_phase <= r_phase_mem[motor_c];
        end
        if (i_cmd.sin_en) begin
            r_sin <= sine_lookup(ph_sel[PHASE_BITS-1 -: ROM_W]);
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.duty_en[0]) r_duty_u <= duty_c;
        if (i_cmd.duty_en[1]) r_duty_v <= duty_c;
        if (i_cmd.duty_en[2]) r_duty_w <= duty_c;
        if (i_cmd.finish) begin
            r_out_sel <= r_sel;
            r_out_u   <= r_duty_u;
            r_out_v   <= r_duty_v;
            r_out_w   <= r_duty_w;
            r_out_dir <= r_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_mem <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_phase_mem[r_motor] <= r_phase + delta;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_stall = r_out_valid && !o_out.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.motor_echo = r_out_sel;
    assign o_out.duty_u     = r_out_u;
    assign o_out.duty_v     = r_out_v;
    assign o_out.duty_w     = r_out_w;
    assign o_out.direction  = r_out_dir;

    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> o_out.valid)
        else $error("finished item not presented");

    a_duty_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(i_cmd.duty_en))
        else $error("two duty registers loaded at once");

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.finish |=> $stable(r_phase_mem))
        else $error("phase changed outside item completion");
endmodule

### sv/three_phase_sine_pwm_generator.sv
// Channel   Dir  Handshake      Beat contents
// i_in      in   valid/ready    motor_select, speed_command
// o_out     out  valid/ready    motor_echo, duty_u, duty_v, duty_w, direction
// APB       in   psel/penable   phase_step_gain at 0x0, direction_deadband at 0x4
//
// Each item runs the accept, three sine lookups overlapped with four turns of the
// single shared 17x17 multiplier (three phases and the phase step), then write-back.
// The result register frees the input side: a new beat is taken while a
// result still waits; only the final write-back stalls on a full output.
// Reset (synchronous, active low) zeroes both phase accumulators and loads the
// register defaults.
module three_phase_sine_pwm_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tpsg_in_if.sink                           i_in,
    tpsg_out_if.source                        o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tpsg_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [tpsg_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [tpsg_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import tpsg_pkg::*;

    t_cmd              cmd;
    t_stat             stat;
    logic              in_ready;
    logic [GAIN_W-1:0] gain;
    logic [DB_W-1:0]   deadband;

    assign i_in.ready = in_ready;

    tpsg_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_gain     (gain),
        .o_deadband (deadband)
    );

    tpsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    tpsg_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_motor_select  (i_in.motor_select),
        .i_speed_command (i_in.speed_command),
        .i_gain          (gain),
        .i_deadband      (deadband),
        .o_out           (o_out)
    );
endmodule
